### hdl/slp_pkg.sv
// slp_pkg: shared types and constants of the standardized linear predictor
// used by slp_serial_unit and standardized_linear_predictor; no dependencies
package slp_pkg;

  localparam int DATA_W  = 32;
  localparam int SCALE_W = 31;
  localparam int PRED_W  = 48;
  localparam int ACC_W   = 64;
  localparam int PROD_W  = 64;
  localparam int CNT_W   = 5;

  // quotient bits below the saturation point, produced msb first
  localparam logic [CNT_W-1:0] ITER_LAST = 5'd30;

  localparam logic CFG_FEATURE_COUNT = 1'b0;
  localparam logic CFG_INTERCEPT     = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_FINISH
  } slp_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_ABS,
    U_CHECK,
    U_ITER,
    U_DONE
  } slp_ustate_t;

  typedef struct packed {
    logic               start;
    logic [DATA_W-1:0]  feature;
    logic [DATA_W-1:0]  mean;
    logic [SCALE_W-1:0] scale;
    logic [DATA_W-1:0]  weight;
  } slp_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] term;
  } slp_rsp_t;

endpackage

### hdl/standardized_linear_predictor.sv
// A load transaction (tuser = 0) writes one feature's mean, scale and weight
// and leaves the input ready for the next transaction. A feature transaction
// (tuser = 1) runs one table read, setup (difference, absolute value, zero and
// saturation check), bit-serial restoring division with a shift-add multiply
// by the weight, and an accumulate step before the next acceptance; when the
// standardized value is zero or saturates the division is skipped. Elements
// past the feature count are not computed and leave the input ready. After the
// last element of a row the prediction moves into the output register, which
// frees the input side; that step waits while the previous result is still there.
// Tables hold MAX_FEATURES entries and must be loaded before use.
//
// standardized_linear_predictor: top level, tables, accumulator and row control
// depends on slp_pkg and slp_serial_unit
module standardized_linear_predictor
  import slp_pkg::*;
#(
  parameter int MAX_FEATURES = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // entry_index[5:0], mean_value[37:6], scale_value[68:38],
  // weight_value[100:69], feature_value[132:101], zero pad[135:133]
  input  logic [135:0]  in_tdata,
  // mode[0]
  input  logic          in_tuser,
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  // prediction[47:0]
  output logic [47:0]   out_tdata,
  // status[1:0]
  output logic [1:0]    out_tuser,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_wdata
);

  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CW = $clog2(MAX_FEATURES + 2);
  localparam int EW = (CW > 7) ? CW : 7;
  localparam int MW = DATA_W + SCALE_W + DATA_W;

  slp_state_t state_r, state_nxt;

  logic [6:0]              fc_r;
  logic [DATA_W-1:0]       icpt_r;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0]       x_r, x_nxt;
  logic                    last_r, last_nxt;
  logic [MW-1:0]           rd_data_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [PRED_W-1:0]       out_pred_r, out_pred_nxt;
  logic [1:0]              out_status_r, out_status_nxt;

  logic [MW-1:0] entry_mem [MAX_FEATURES];

  slp_req_t req;
  slp_rsp_t rsp;

  logic          in_acc;
  logic          is_feat;
  logic          is_load;
  logic          load_ok;
  logic [EW-1:0] fc_ext;
  logic [EW-1:0] n_ext;
  logic [CW-1:0] n_eff;
  logic          pos_lt_n;
  logic          out_free;
  logic          sat_hi;
  logic          sat_lo;

  assign in_acc   = in_tvalid && in_tready;
  assign is_feat  = in_acc && in_tuser;
  assign is_load  = in_acc && !in_tuser;
  assign load_ok  = ({26'd0, in_tdata[5:0]} < 32'(MAX_FEATURES));
  assign fc_ext   = EW'(fc_r);
  assign n_ext    = (fc_r == '0) ? EW'(1)
                  : ((fc_ext > EW'(MAX_FEATURES)) ? EW'(MAX_FEATURES) : fc_ext);
  assign n_eff    = CW'(n_ext);
  assign pos_lt_n = (pos_r < n_eff);
  assign out_free = !out_valid_r || out_tready;
  assign sat_hi   = !acc_r[ACC_W-1] && (|acc_r[ACC_W-2:PRED_W-1]);
  assign sat_lo   = acc_r[ACC_W-1] && !(&acc_r[ACC_W-2:PRED_W-1]);

  slp_serial_unit u_serial (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // table: mean[31:0], scale[62:32], weight[94:63]
  always_ff @(posedge clk) begin
    if (is_load && load_ok) begin
      entry_mem[AW'(in_tdata[5:0])] <= {in_tdata[100:69], in_tdata[68:38], in_tdata[37:6]};
    end
    rd_data_r <= entry_mem[pos_r[AW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (is_feat) begin
          if (pos_lt_n) state_nxt = S_READ;
          else if (in_tlast) state_nxt = S_FINISH;
        end
      end
      S_READ:  state_nxt = S_CALC;
      S_CALC: begin
        if (rsp.done) state_nxt = last_r ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = rst_n && (state_r == S_IDLE);
    req.start   = (state_r == S_READ);
    req.feature = x_r;
    req.mean    = rd_data_r[DATA_W-1:0];
    req.scale   = rd_data_r[DATA_W+SCALE_W-1:DATA_W];
    req.weight  = rd_data_r[MW-1:DATA_W+SCALE_W];
    out_tvalid  = out_valid_r;
    out_tdata   = out_pred_r;
    out_tuser   = out_status_r;
  end

  always_comb begin
    pos_nxt        = pos_r;
    acc_nxt        = acc_r;
    x_nxt          = x_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_pred_nxt   = out_pred_r;
    out_status_nxt = out_status_r;
    case (state_r)
      S_IDLE: begin
        if (is_feat) begin
          x_nxt    = in_tdata[132:101];
          last_nxt = in_tlast;
          // intercept is sampled at the first element of a row
          if (pos_r == '0) acc_nxt = ACC_W'($signed(icpt_r));
          if (!pos_lt_n) pos_nxt = n_eff + CW'(1);
        end
      end
      S_CALC: begin
        if (rsp.done) begin
          acc_nxt = acc_r + ($signed(rsp.term) >>> 16);
          pos_nxt = pos_r + CW'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sat_hi) out_pred_nxt = {1'b0, {(PRED_W-1){1'b1}}};
          else if (sat_lo) out_pred_nxt = {1'b1, {(PRED_W-1){1'b0}}};
          else out_pred_nxt = acc_r[PRED_W-1:0];
          if (pos_r > n_eff) out_status_nxt = ST_LONG;
          else if (pos_r < n_eff) out_status_nxt = ST_SHORT;
          else out_status_nxt = ST_OK;
          acc_nxt = '0;
          pos_nxt = '0;
        end
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fc_r        <= 7'd1;
      icpt_r      <= '0;
      pos_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FEATURE_COUNT: fc_r <= cfg_wdata[6:0];
          CFG_INTERCEPT:     icpt_r <= cfg_wdata;
          default:           fc_r <= fc_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    last_r       <= last_nxt;
    out_pred_r   <= out_pred_nxt;
    out_status_r <= out_status_nxt;
  end

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == S_CALC))
    else $error("serial unit finished outside the compute state");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= CW'(MAX_FEATURES + 1))
    else $error("feature position beyond count plus one");

  a_feat_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (is_feat && pos_lt_n) |=> (state_r == S_READ))
    else $error("accepted element did not start a table read");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_OK || out_status_r == ST_SHORT ||
                     out_status_r == ST_LONG))
    else $error("invalid status code on result");

endmodule

### hdl/slp_serial_unit.sv
// slp_serial_unit: bit-serial standardize-and-weight unit, restoring division
// of (x - mean) * 2^16 by scale with a shift-add multiply by the weight
// depends on slp_pkg
module slp_serial_unit
  import slp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  slp_req_t req,
  output slp_rsp_t rsp
);

  slp_ustate_t state_r, state_nxt;

  logic signed [DATA_W:0]   diff_r, diff_nxt;
  logic [SCALE_W-1:0]       scale_r, scale_nxt;
  logic [DATA_W-1:0]        w_r, w_nxt;
  logic                     neg_r, neg_nxt;
  logic [DATA_W-1:0]        mag_r, mag_nxt;
  logic signed [DATA_W:0]   ws_r, ws_nxt;
  logic [SCALE_W-1:0]       rem_r, rem_nxt;
  logic [SCALE_W-1:0]       dvd_r, dvd_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;

  logic                     is_zero;
  logic                     is_sat;
  logic signed [PROD_W-1:0] ws_ext;
  logic signed [PROD_W-1:0] ws_shift;
  logic [DATA_W-1:0]        trial;
  logic [DATA_W-1:0]        trial_sub;
  logic                     trial_ge;
  logic signed [DATA_W:0]   w_sext;

  assign is_zero   = (mag_r == '0);
  // quotient would reach 2^31: mag * 2^16 >= scale * 2^31
  assign is_sat    = ({14'd0, mag_r} >= {scale_r, 15'd0});
  assign ws_ext    = PROD_W'(ws_r);
  assign ws_shift  = ws_ext <<< 31;
  assign trial     = {rem_r, dvd_r[SCALE_W-1]};
  assign trial_ge  = (trial >= {1'b0, scale_r});
  assign trial_sub = trial - {1'b0, scale_r};
  assign w_sext    = {w_r[DATA_W-1], w_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      U_IDLE: begin
        if (req.start) state_nxt = U_ABS;
      end
      U_ABS:   state_nxt = U_CHECK;
      U_CHECK: begin
        if (is_zero || is_sat) state_nxt = U_DONE;
        else state_nxt = U_ITER;
      end
      U_ITER: begin
        if (cnt_r == ITER_LAST) state_nxt = U_DONE;
      end
      U_DONE:  state_nxt = U_IDLE;
      default: state_nxt = U_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state_r == U_DONE);
    rsp.term = prod_r;
  end

  always_comb begin
    diff_nxt  = diff_r;
    scale_nxt = scale_r;
    w_nxt     = w_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    ws_nxt    = ws_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          diff_nxt  = $signed({req.feature[DATA_W-1], req.feature})
                    - $signed({req.mean[DATA_W-1], req.mean});
          scale_nxt = req.scale;
          w_nxt     = req.weight;
        end
      end
      U_ABS: begin
        neg_nxt = diff_r[DATA_W];
        mag_nxt = diff_r[DATA_W] ? DATA_W'(-diff_r) : diff_r[DATA_W-1:0];
        // fold the sign of the quotient into the weight
        ws_nxt  = diff_r[DATA_W] ? -w_sext : w_sext;
      end
      U_CHECK: begin
        prod_nxt = '0;
        cnt_nxt  = '0;
        if (is_zero) begin
          prod_nxt = '0;
        end else if (is_sat) begin
          prod_nxt = neg_r ? ws_shift : ws_shift - ws_ext;
        end else begin
          rem_nxt = {14'd0, mag_r[DATA_W-1:15]};
          dvd_nxt = {mag_r[14:0], 16'd0};
        end
      end
      U_ITER: begin
        rem_nxt  = trial_ge ? trial_sub[SCALE_W-1:0] : trial[SCALE_W-1:0];
        dvd_nxt  = {dvd_r[SCALE_W-2:0], 1'b0};
        prod_nxt = (prod_r <<< 1) + (trial_ge ? ws_ext : PROD_W'(0));
        cnt_nxt  = cnt_r + CNT_W'(1);
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r  <= diff_nxt;
    scale_r <= scale_nxt;
    w_r     <= w_nxt;
    neg_r   <= neg_nxt;
    mag_r   <= mag_nxt;
    ws_r    <= ws_nxt;
    rem_r   <= rem_nxt;
    dvd_r   <= dvd_nxt;
    prod_r  <= prod_nxt;
  end

endmodule

### bench/testbench.sv
// testbench: self-checking bench for standardized_linear_predictor
// streams table loads and feature rows, predicts each row result and compares it
// depends on slp_pkg and the standardized_linear_predictor rtl
module testbench;
  import slp_pkg::*;

  localparam int MAX_FEATURES = 64;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_FEATURE = 1'b1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 80;
  localparam int SEGMENT_ITEMS = 50;
  localparam longint PRED_HI = (longint'(1) <<< 47) - 1;
  localparam longint PRED_LO = -(longint'(1) <<< 47);

  typedef struct {
    logic        mode;
    logic [5:0]  entry;
    logic [31:0] mean;
    logic [30:0] scale;
    logic [31:0] weight;
    logic [31:0] feature;
    logic        row_last;
  } stream_item_t;

  typedef struct packed {
    logic [47:0] prediction;
    logic [1:0]  status;
  } row_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [31:0]  cfg_wdata = '0;

  standardized_linear_predictor #(
    .MAX_FEATURES(MAX_FEATURES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wire in_fire = rst_n && in_tvalid && (in_tready === 1'b1);
  wire out_fire = rst_n && (out_tvalid === 1'b1) && out_tready;

  stream_item_t stream_items[$];
  row_result_t  pending_predictions[$];
  int           send_idle_pct = 22;
  int           recv_idle_pct = 76;
  logic         in_accepted = 1'b0;
  int           stall_cycles = 0;
  int           fail_count = 0;

  // predictor copy of the block state
  logic [31:0]  mean_tab[MAX_FEATURES];
  logic [30:0]  scale_tab[MAX_FEATURES];
  logic [31:0]  weight_tab[MAX_FEATURES];
  longint       row_acc = 0;
  int           row_pos = 0;
  logic [6:0]   count_reg = 7'd1;
  logic [31:0]  intercept_reg = '0;

  task automatic append_item(stream_item_t it);
    stream_items = {stream_items, it};
  endtask

  function automatic int effective_count(logic [6:0] c);
    if (c == 0) return 1;
    if (c > MAX_FEATURES) return MAX_FEATURES;
    return int'(c);
  endfunction

  // weighted standardized term, floored to q16.16
  function automatic longint standardized_term(logic [31:0] x, logic [31:0] mu,
                                               logic [30:0] sc, logic [31:0] w);
    longint diff;
    longint mag;
    longint quo;
    longint q;
    diff = longint'($signed(x)) - longint'($signed(mu));
    mag = (diff < 0) ? -diff : diff;
    if (mag == 0) begin
      q = 0;
    end else if (sc == 0) begin
      q = (diff < 0) ? -longint'(64'h8000_0000) : longint'(64'h7FFF_FFFF);
    end else begin
      quo = (mag <<< 16) / longint'({33'b0, sc});
      if (diff < 0) q = (quo > longint'(64'h8000_0000)) ? -longint'(64'h8000_0000) : -quo;
      else q = (quo > longint'(64'h7FFF_FFFF)) ? longint'(64'h7FFF_FFFF) : quo;
    end
    return (q * longint'($signed(w))) >>> 16;
  endfunction

  task automatic step_prediction(stream_item_t it);
    int n;
    longint pred;
    row_result_t res;
    n = effective_count(count_reg);
    if (it.mode == MODE_LOAD) begin
      mean_tab[it.entry] = it.mean;
      scale_tab[it.entry] = it.scale;
      weight_tab[it.entry] = it.weight;
      return;
    end
    if (row_pos == 0) row_acc = longint'($signed(intercept_reg));
    if (row_pos < n) begin
      row_acc += standardized_term(it.feature, mean_tab[row_pos], scale_tab[row_pos],
                                   weight_tab[row_pos]);
      row_pos++;
    end else begin
      row_pos = n + 1;
    end
    if (!it.row_last) return;
    if (row_pos > n) res.status = ST_LONG;
    else if (row_pos < n) res.status = ST_SHORT;
    else res.status = ST_OK;
    pred = row_acc;
    if (pred > PRED_HI) pred = PRED_HI;
    if (pred < PRED_LO) pred = PRED_LO;
    res.prediction = pred[47:0];
    pending_predictions = {pending_predictions, res};
    row_acc = 0;
    row_pos = 0;
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin : stream_driver
    stream_item_t cur;
    if (!in_tvalid || in_accepted) begin
      if (stream_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur = stream_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {3'b000, cur.feature, cur.weight, cur.scale, cur.mean, cur.entry};
        in_tuser <= cur.mode;
        in_tlast <= cur.row_last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: predicts on input transactions, checks output transactions
  always @(posedge clk) begin : result_monitor
    stream_item_t seen;
    row_result_t due;
    in_accepted <= in_fire;
    if (in_fire) begin
      seen.mode = in_tuser;
      seen.entry = in_tdata[5:0];
      seen.mean = in_tdata[37:6];
      seen.scale = in_tdata[68:38];
      seen.weight = in_tdata[100:69];
      seen.feature = in_tdata[132:101];
      seen.row_last = in_tlast;
      step_prediction(seen);
    end
    if (out_fire) begin
      if (pending_predictions.size() == 0) begin
        $error("unexpected result: prediction %h status %0d", out_tdata, out_tuser);
        fail_count++;
      end else begin
        due = pending_predictions.pop_front();
        if (out_tdata !== due.prediction) begin
          $error("prediction mismatch: expected %h actual %h", due.prediction, out_tdata);
          fail_count++;
        end
        if (out_tuser !== due.status) begin
          $error("status mismatch: expected %0d actual %0d", due.status, out_tuser);
          fail_count++;
        end
      end
    end
    if (in_fire || out_fire) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("standardized_linear_predictor verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(4))
      0: return 32'($urandom_range(2097152)) - 32'd1048576;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      2: return 32'($urandom_range(524288)) - 32'd262144;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [30:0] rand_scale();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return 31'h7FFF_FFFF;
    if (r <= 4) return 31'($urandom_range(1, 262144));
    return 31'($urandom());
  endfunction

  function automatic stream_item_t make_load(logic [5:0] idx, logic [31:0] mu,
                                             logic [30:0] sc, logic [31:0] w);
    stream_item_t it;
    it.mode = MODE_LOAD;
    it.entry = idx;
    it.mean = mu;
    it.scale = sc;
    it.weight = w;
    it.feature = $urandom();
    it.row_last = $urandom_range(1);
    return it;
  endfunction

  // unused load fields carry random noise
  function automatic stream_item_t make_element(logic [31:0] x, logic row_last);
    stream_item_t it;
    it.mode = MODE_FEATURE;
    it.entry = 6'($urandom());
    it.mean = $urandom();
    it.scale = 31'($urandom());
    it.weight = $urandom();
    it.feature = x;
    it.row_last = row_last;
    return it;
  endfunction

  function automatic stream_item_t random_load();
    return make_load(6'($urandom()), rand_q16(), rand_scale(), rand_q16());
  endfunction

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    if (idx == CFG_FEATURE_COUNT) count_reg = value[6:0];
    else intercept_reg = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    while (stream_items.size() != 0 || in_tvalid || pending_predictions.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_row(logic [31:0] x0, logic [31:0] x1, logic [31:0] x2);
    append_item(make_element(x0, 1'b0));
    append_item(make_element(x1, 1'b0));
    append_item(make_element(x2, 1'b1));
  endtask

  task automatic push_directed();
    for (int i = 0; i < 3; i++)
      append_item(make_load(6'(i), 32'h0, 31'h0, 32'h8000_0000));
    // saturation high through zero scale
    push_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 3; i++)
      append_item(make_load(6'(i), 32'h0, 31'h0, 32'h7FFF_FFFF));
    // saturation low
    push_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // zero difference with zero scale
    push_row(32'h0, 32'h0, 32'h0);
    append_item(make_load(6'd0, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF));
    append_item(make_load(6'd1, 32'h7FFF_FFFF, 31'd1, 32'h8000_0000));
    append_item(make_load(6'd2, 32'h0001_0000, 31'h0001_0000, 32'h0002_0000));
    // short row
    append_item(make_element(32'h7FFF_FFFF, 1'b1));
    // long row
    append_item(make_element(32'h8000_0000, 1'b0));
    append_item(make_element(32'h8000_0000, 1'b0));
    append_item(make_element(32'h0003_0000, 1'b0));
    append_item(make_element(32'hFFFF_FFFF, 1'b1));
    // load in the middle of a row
    append_item(make_element(32'h0, 1'b0));
    append_item(make_load(6'd1, 32'h0, 31'h0000_8000, 32'h0000_4000));
    append_item(make_element(32'h0001_0000, 1'b0));
    append_item(make_element(32'h0, 1'b1));
  endtask

  task automatic push_random_rows(int target);
    int n;
    int len;
    int r;
    int produced;
    n = effective_count(count_reg);
    produced = 0;
    while (produced < target) begin
      r = $urandom_range(99);
      if (r < 70 || n == 1 && r < 85) len = n;
      else if (r < 85) len = $urandom_range(1, n - 1);
      else len = n + $urandom_range(1, 3);
      for (int e = 0; e < len; e++) begin
        if ($urandom_range(9) == 0) begin
          append_item(random_load());
          produced++;
        end
        append_item(make_element(rand_q16(), e == len - 1));
        produced++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every table entry gets written before any row reads it
    for (int i = 0; i < MAX_FEATURES; i++)
      append_item(make_load(6'(i), rand_q16(), rand_scale(), rand_q16()));
    wait_drained();

    write_reg(CFG_FEATURE_COUNT, 32'd3);
    write_reg(CFG_INTERCEPT, 32'h8000_0000);
    push_directed();
    wait_drained();

    for (int s = 0; s < 6; s++) begin
      if (s < 2) begin
        send_idle_pct = 22;
        recv_idle_pct = 76;
      end else if (s < 4) begin
        send_idle_pct = 76;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (s)
        0: begin
          write_reg(CFG_FEATURE_COUNT, 32'd0);
          write_reg(CFG_INTERCEPT, 32'h7FFF_FFFF);
        end
        1: begin
          write_reg(CFG_FEATURE_COUNT, 32'd64);
          write_reg(CFG_INTERCEPT, $urandom());
        end
        2: begin
          write_reg(CFG_FEATURE_COUNT, 32'd127);
          write_reg(CFG_INTERCEPT, 32'h0);
        end
        3: begin
          write_reg(CFG_FEATURE_COUNT, 32'd1);
          write_reg(CFG_INTERCEPT, $urandom());
        end
        4: begin
          write_reg(CFG_FEATURE_COUNT, 32'($urandom_range(2, 8)));
          write_reg(CFG_INTERCEPT, 32'h8000_0000);
        end
        default: begin
          write_reg(CFG_FEATURE_COUNT, 32'($urandom_range(2, 16)));
          write_reg(CFG_INTERCEPT, $urandom());
        end
      endcase
      push_random_rows(SEGMENT_ITEMS);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("standardized_linear_predictor verification clean");
    end else begin
      $display("standardized_linear_predictor verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/slp_pkg.sv
hdl/slp_serial_unit.sv
hdl/standardized_linear_predictor.sv
bench/testbench.sv
